// ===== hw/rtl/accel_fall_detector_core_assert.svh =====
// Assertion macros shared by the fall detector checker.
`ifndef ACCEL_FALL_DETECTOR_CORE_ASSERT_SVH
`define ACCEL_FALL_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define AFD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fall detector check failed");

// Next-cycle implication.
`define AFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fall detector check failed");

`endif

// ===== hw/rtl/afd_pkg.sv =====
// Types and constants of the accelerometer fall detector.
package afd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_FREE      = 3'd1,
		PH_IMPACT    = 3'd2,
		PH_WATCH     = 3'd3,
		PH_CONFIRMED = 3'd4
	} phase_t;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_FREE_FALL_LEVEL = 3'd0;
	localparam logic [2:0] REG_IMPACT_LEVEL    = 3'd1;
	localparam logic [2:0] REG_STILL_LEVEL     = 3'd2;
	localparam logic [2:0] REG_IMPACT_WINDOW   = 3'd3;
	localparam logic [2:0] REG_SETTLE          = 3'd4;
	localparam logic [2:0] REG_WATCH           = 3'd5;

	localparam logic [31:0] RST_FREE_FALL_LEVEL = 32'd377487;
	localparam logic [31:0] RST_IMPACT_LEVEL    = 32'd37748736;
	localparam logic [31:0] RST_STILL_LEVEL     = 32'd9437184;
	localparam logic [15:0] RST_IMPACT_WINDOW   = 16'd500;
	localparam logic [15:0] RST_SETTLE          = 16'd1000;
	localparam logic [15:0] RST_WATCH           = 16'd3000;

	typedef struct packed {
		logic [31:0] free_fall_level_sq;
		logic [31:0] impact_level_sq;
		logic [31:0] still_level_sq;
		logic [15:0] impact_window_ms;
		logic [15:0] settle_ms;
		logic [15:0] watch_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] magnitude_sq;
		phase_t      detector_state;
	} res_t;

endpackage

// ===== hw/rtl/afd_square.sv =====
// Absolute value and square of one signed axis reading.
module afd_square (
	input  logic signed [15:0] axis,
	output logic [31:0]        square
);

	logic [16:0] mag;
	logic [33:0] prod;

	// most negative reading gives 32768, hence 17 bits
	always_comb begin
		if (axis[15]) begin
			mag = 17'h10000 - {1'b0, axis};
		end else begin
			mag = {1'b0, axis};
		end
	end

	assign prod   = mag * mag;
	assign square = prod[31:0];

endmodule

// ===== hw/rtl/afd_fsm.sv =====
// Magnitude sum, threshold compares and the five-phase fall detector.
module afd_fsm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               clear,
	input  logic [31:0]        sq_x,
	input  logic [31:0]        sq_y,
	input  logic [31:0]        sq_z,
	input  logic [31:0]        now_ms,
	input  afd_pkg::cfg_t      cfg,
	output afd_pkg::res_t      res
);

	afd_pkg::phase_t phase_q, phase_d;
	logic [31:0]     phase_start_q, phase_start_d;
	logic [31:0]     mag;
	logic [31:0]     elapsed;

	// three squares of at most 2^30 each, so the sum never wraps
	assign mag     = sq_x + sq_y + sq_z;
	assign elapsed = now_ms - phase_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= afd_pkg::PH_IDLE;
			phase_start_q <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			phase_start_q <= phase_start_d;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		phase_start_d = phase_start_q;
		if (clear) begin
			phase_d = afd_pkg::PH_IDLE;
		end else begin
			case (phase_q)
				afd_pkg::PH_FREE: begin
					if (mag > cfg.impact_level_sq && elapsed < {16'd0, cfg.impact_window_ms}) begin
						phase_d       = afd_pkg::PH_IMPACT;
						phase_start_d = now_ms;
					end else if (elapsed >= {16'd0, cfg.impact_window_ms}) begin
						phase_d = afd_pkg::PH_IDLE;
					end
				end
				afd_pkg::PH_IMPACT: begin
					if (elapsed > {16'd0, cfg.settle_ms}) begin
						phase_d       = afd_pkg::PH_WATCH;
						phase_start_d = now_ms;
					end
				end
				afd_pkg::PH_WATCH: begin
					if (elapsed > {16'd0, cfg.watch_ms} && mag < cfg.still_level_sq) begin
						phase_d = afd_pkg::PH_CONFIRMED;
					end
				end
				afd_pkg::PH_CONFIRMED: begin
					phase_d = afd_pkg::PH_CONFIRMED;
				end
				default: begin
					if (mag < cfg.free_fall_level_sq) begin
						phase_d       = afd_pkg::PH_FREE;
						phase_start_d = now_ms;
					end else begin
						phase_d = afd_pkg::PH_IDLE;
					end
				end
			endcase
		end
		res.magnitude_sq   = clear ? 32'd0 : mag;
		res.detector_state = phase_d;
	end

endmodule

// ===== hw/rtl/accel_fall_detector_core.sv =====
// Accelerometer fall detector: three-axis samples in, one status beat out per beat.
//
// Slave stream: s_tdata carries x, y, z (signed counts) and the millisecond
// timestamp; s_tuser is the action bit (0 sample, 1 clear to idle).
// Master stream: one beat per input beat with the squared magnitude, the
// detector phase (0 idle .. 4 confirmed) and the fall flag.
// Configuration: cfg_valid/cfg_ready with a 3-bit register index and 32-bit
// data; an unknown index is ignored. Write only while the block is idle.
// Pipeline: input register, squaring stage, phase update into the output
// register.
// Throughput: one beat per cycle while the master side accepts; the phase
// register is updated in the last stage, so consecutive beats follow each other without a gap.
// Reset: phase goes to idle, the phase start time to zero and every
// configuration register to its default; all stages empty.
// Stall: a held master beat keeps its data; stages behind it fill up and
// s_tready falls only when all three are occupied.
module accel_fall_detector_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
	input  logic [0:0]  s_tuser,   // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // magnitude_sq[31:0], detector_state[34:32], fall_flag[35], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	afd_pkg::cfg_t cfg_q;

	logic               valid_s1, valid_s2, m_valid_q;
	logic               action_s1, action_s2;
	logic signed [15:0] ax_s1, ay_s1, az_s1;
	logic [31:0]        now_s1, now_s2;
	logic [31:0]        sqx, sqy, sqz;
	logic [31:0]        sqx_s2, sqy_s2, sqz_s2;
	logic               ready_out, ready_s2, ready_s1, step;
	afd_pkg::res_t      res, res_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.free_fall_level_sq <= afd_pkg::RST_FREE_FALL_LEVEL;
			cfg_q.impact_level_sq    <= afd_pkg::RST_IMPACT_LEVEL;
			cfg_q.still_level_sq     <= afd_pkg::RST_STILL_LEVEL;
			cfg_q.impact_window_ms   <= afd_pkg::RST_IMPACT_WINDOW;
			cfg_q.settle_ms          <= afd_pkg::RST_SETTLE;
			cfg_q.watch_ms           <= afd_pkg::RST_WATCH;
		end else if (cfg_valid) begin
			case (cfg_index)
				afd_pkg::REG_FREE_FALL_LEVEL: cfg_q.free_fall_level_sq <= cfg_data;
				afd_pkg::REG_IMPACT_LEVEL:    cfg_q.impact_level_sq    <= cfg_data;
				afd_pkg::REG_STILL_LEVEL:     cfg_q.still_level_sq     <= cfg_data;
				afd_pkg::REG_IMPACT_WINDOW:   cfg_q.impact_window_ms   <= cfg_data[15:0];
				afd_pkg::REG_SETTLE:          cfg_q.settle_ms          <= cfg_data[15:0];
				afd_pkg::REG_WATCH:           cfg_q.watch_ms           <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// each stage moves when the one ahead is empty or moving
	assign ready_out = !m_valid_q || m_tready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign s_tready  = ready_s1;
	assign step      = valid_s2 && ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				m_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			action_s1 <= s_tuser[0];
			ax_s1     <= s_tdata[15:0];
			ay_s1     <= s_tdata[31:16];
			az_s1     <= s_tdata[47:32];
			now_s1    <= s_tdata[79:48];
		end
		if (ready_s2 && valid_s1) begin
			action_s2 <= action_s1;
			sqx_s2    <= sqx;
			sqy_s2    <= sqy;
			sqz_s2    <= sqz;
			now_s2    <= now_s1;
		end
		if (step) begin
			res_q <= res;
		end
	end

	afd_square u_sq_x (.axis(ax_s1), .square(sqx));
	afd_square u_sq_y (.axis(ay_s1), .square(sqy));
	afd_square u_sq_z (.axis(az_s1), .square(sqz));

	afd_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.clear  (action_s2),
		.sq_x   (sqx_s2),
		.sq_y   (sqy_s2),
		.sq_z   (sqz_s2),
		.now_ms (now_s2),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0,
		(res_q.detector_state == afd_pkg::PH_CONFIRMED),
		res_q.detector_state,
		res_q.magnitude_sq};

endmodule

// ===== hw/rtl/afd_checker.sv =====
// Port-level checks on the fall detector, bound to the top level.
`include "accel_fall_detector_core_assert.svh"

module afd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata
);

	logic       last_conf_q;
	logic [2:0] m_state;

	assign m_state = m_tdata[34:32];

	// remembers whether the last delivered beat reported a confirmed fall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_conf_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			last_conf_q <= (m_state == afd_pkg::PH_CONFIRMED);
		end
	end

	`AFD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`AFD_ASSERT_NOW(a_flag_match, m_tvalid, m_tdata[35] == (m_state == afd_pkg::PH_CONFIRMED))
	`AFD_ASSERT_NOW(a_fall_sticks, m_tvalid && last_conf_q, m_state[2] || m_state == afd_pkg::PH_IDLE)
	`AFD_ASSERT_NOW(a_mag_bound, m_tvalid, m_tdata[31:0] <= 32'd3221225472)
	`AFD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[39:36] == 4'd0)

endmodule

bind accel_fall_detector_core afd_checker u_afd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
